@@ hw/rtl/length_prefix_to_annexb_unit_assert.svh @@
// Assertion macros for the length-prefix to Annex B converter.
// Every macro samples on clk and is disabled while rst is high.
`ifndef LENGTH_PREFIX_TO_ANNEXB_UNIT_ASSERT_SVH
`define LENGTH_PREFIX_TO_ANNEXB_UNIT_ASSERT_SVH

// Same-cycle implication
`define LPAB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpab assertion failed");

// Next-cycle implication
`define LPAB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpab assertion failed");

`endif

@@ hw/rtl/lpab_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the length-prefix to Annex B converter.
// No dependencies.
package lpab_pkg;

  // Input opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // Queue command kinds
  localparam logic [1:0] CMD_SC   = 2'd0;  // four start-code bytes
  localparam logic [1:0] CMD_BYTE = 2'd1;  // one payload byte
  localparam logic [1:0] CMD_EOF  = 2'd2;  // end-of-frame marker

  // Output kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  localparam logic [2:0] PREFIX_BYTES_RESET = 3'd4;
  localparam int         QUEUE_DEPTH        = 4;

  localparam logic [7:0] SYNC_BYTES [4] = '{8'h00, 8'h00, 8'h00, 8'h01};

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        nal_end;
    logic [63:0] ts;
  } cmd_t;

endpackage

@@ hw/rtl/lpab_queue.sv @@
`timescale 1ns / 1ps
// Small command queue between the classifier and the output sequencer.
// Depends on lpab_pkg.
module lpab_queue #(
  parameter int Depth = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lpab_pkg::cmd_t push_data,
  output logic          space,
  output logic          valid,
  output lpab_pkg::cmd_t head,
  input  logic          pop
);
  import lpab_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  cmd_t            entries [Depth];
  logic [PtrW-1:0] wptr;
  logic [PtrW-1:0] rptr;
  logic [CntW-1:0] count;

  assign space = (count != Full);
  assign valid = (count != '0);
  assign head  = entries[rptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == LastPtr) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == LastPtr) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/lpab_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input items, tracks the sample and NAL prefix state,
// and turns each item into at most one queue command. Depends on lpab_pkg.
module lpab_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_data,
  input  logic           accept,
  input  logic [1:0]     opcode,
  input  logic [7:0]     data_byte,
  input  logic [30:0]    sample_length,
  input  logic [63:0]    timestamp,
  output logic           push,
  output lpab_pkg::cmd_t push_data
);
  import lpab_pkg::*;

  localparam logic [1:0] PH_PREFIX  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_HALT    = 2'd2;

  logic [2:0]  prefix_bytes;
  logic [1:0]  phase, phase_next;
  logic [2:0]  prefix_count, prefix_count_next;
  logic [31:0] length_accum, length_accum_next;
  logic [31:0] payload_left, payload_left_next;
  logic [30:0] remain, remain_next;      // bytes left in the sample
  logic [63:0] sample_pts, sample_pts_next;

  logic [2:0]  width;
  logic [2:0]  count_inc;
  logic [31:0] accum_new;
  logic        emit;
  cmd_t        cmd;

  // Prefix width as used: zero acts as one, above four acts as four
  always_comb begin
    if (prefix_bytes == 3'd0) begin
      width = 3'd1;
    end else if (prefix_bytes > 3'd4) begin
      width = 3'd4;
    end else begin
      width = prefix_bytes;
    end
  end

  assign count_inc = prefix_count + 3'd1;
  assign accum_new = {((prefix_count == 3'd0) ? 24'd0 : length_accum[23:0]), data_byte};

  // Item classification and state update
  always_comb begin
    phase_next        = phase;
    prefix_count_next = prefix_count;
    length_accum_next = length_accum;
    payload_left_next = payload_left;
    remain_next       = remain;
    sample_pts_next   = sample_pts;
    emit              = 1'b0;
    cmd.kind          = CMD_BYTE;
    cmd.data          = data_byte;
    cmd.nal_end       = 1'b0;
    cmd.ts            = sample_pts;

    unique case (opcode)
      OP_START: begin
        remain_next       = sample_length;
        sample_pts_next   = timestamp;
        phase_next        = PH_PREFIX;
        prefix_count_next = '0;
        length_accum_next = '0;
        payload_left_next = '0;
      end
      OP_END: begin
        emit              = 1'b1;
        cmd.kind          = CMD_EOF;
        cmd.data          = '0;
        phase_next        = PH_HALT;
        prefix_count_next = '0;
        length_accum_next = '0;
        payload_left_next = '0;
      end
      OP_DATA: begin
        if (phase != PH_HALT && remain != '0) begin
          if (phase == PH_PREFIX) begin
            if (prefix_count == 3'd0 && remain < {28'd0, width}) begin
              // next prefix would run past the sample end
              phase_next = PH_HALT;
            end else begin
              remain_next       = remain - 1'b1;
              length_accum_next = accum_new;
              if (count_inc >= width) begin
                prefix_count_next = '0;
                if (accum_new >= {1'b0, remain}) begin
                  // payload would run past the sample end
                  phase_next = PH_HALT;
                end else begin
                  emit              = 1'b1;
                  cmd.kind          = CMD_SC;
                  cmd.nal_end       = (accum_new == '0);
                  payload_left_next = accum_new;
                  phase_next        = (accum_new == '0) ? PH_PREFIX : PH_PAYLOAD;
                end
              end else begin
                prefix_count_next = count_inc;
              end
            end
          end else begin
            // payload byte, payload_left is nonzero here
            remain_next       = remain - 1'b1;
            payload_left_next = payload_left - 1'b1;
            emit              = 1'b1;
            cmd.nal_end       = (payload_left == 32'd1);
            if (payload_left == 32'd1) begin
              phase_next = PH_PREFIX;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign push      = accept && emit;
  assign push_data = cmd;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_bytes <= PREFIX_BYTES_RESET;
    end else if (cfg_we) begin
      prefix_bytes <= cfg_data;
    end
  end

  // Sample and prefix state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_PREFIX;
      prefix_count <= '0;
      length_accum <= '0;
      payload_left <= '0;
      remain       <= '0;
      sample_pts   <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      prefix_count <= prefix_count_next;
      length_accum <= length_accum_next;
      payload_left <= payload_left_next;
      remain       <= remain_next;
      sample_pts   <= sample_pts_next;
    end
  end

endmodule

@@ hw/rtl/lpab_back.sv @@
`timescale 1ns / 1ps
// Back end: expands queue commands into output items through an output
// register; a start-code command takes four beats. Depends on lpab_pkg.
module lpab_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  lpab_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_kind,
  output logic [7:0]     out_byte,
  output logic [63:0]    out_timestamp,
  output logic           nal_end,
  output logic           last_of_run
);
  import lpab_pkg::*;

  logic [1:0] sc_idx;     // start-code beat within the head command
  logic       load;
  logic       beat_last;
  logic       kind_b;
  logic [7:0] byte_b;
  logic       nal_end_b;

  assign load = !out_valid || out_ready;

  // Beat contents for the head command
  always_comb begin
    kind_b    = KIND_BYTE;
    byte_b    = q_head.data;
    nal_end_b = q_head.nal_end;
    beat_last = 1'b1;
    unique case (q_head.kind)
      CMD_SC: begin
        byte_b    = SYNC_BYTES[sc_idx];
        beat_last = (sc_idx == 2'd3);
        nal_end_b = beat_last && q_head.nal_end;
      end
      CMD_EOF: begin
        kind_b    = KIND_EOF;
        byte_b    = '0;
        nal_end_b = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign q_pop = load && q_valid && beat_last;

  // Output register and beat counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sc_idx    <= '0;
    end else if (load) begin
      out_valid <= q_valid;
      if (q_valid) begin
        sc_idx <= beat_last ? 2'd0 : sc_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      out_kind      <= kind_b;
      out_byte      <= byte_b;
      out_timestamp <= q_head.ts;
      nal_end       <= nal_end_b;
      last_of_run   <= beat_last;
    end
  end

endmodule

@@ hw/rtl/length_prefix_to_annexb_unit.sv @@
`timescale 1ns / 1ps
// Top level of the length-prefix to Annex B converter: front end, command
// queue and back end. Depends on lpab_pkg, lpab_front, lpab_queue, lpab_back.
//
//  channel   | direction | handshake              | content
//  ----------+-----------+------------------------+---------------------------------
//  s_axis    | in        | s_axis_tvalid/tready   | opcode, data byte, length, time
//  m_axis    | out       | m_axis_tvalid/tready   | stream byte or end marker
//  cfg       | in        | cfg_valid/cfg_ready    | prefix width (3 bits)
//
// Input items are taken one per cycle while the command queue has room.
// Payload bytes and end markers leave one per cycle while m_axis_tready is
// high; a start code is a four-byte burst on the output, absorbed by the queue.
// rst is synchronous and clears all control state. Either side may stall
// independently.
module length_prefix_to_annexb_unit #(
  parameter int QueueDepth = lpab_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,   // data_byte[7:0], sample_length[38:8],
                                       // timestamp[102:39], zero pad [103]
  input  logic [1:0]   s_axis_tuser,   // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,   // out_byte[7:0], out_timestamp[71:8]
  output logic [1:0]   m_axis_tuser,   // out_kind[0], nal_end[1]
  output logic         m_axis_tlast,   // last_of_run
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_data
);
  import lpab_pkg::*;

  logic  accept;
  logic  q_push;
  cmd_t  q_push_data;
  logic  q_space;
  logic  q_valid;
  cmd_t  q_head;
  logic  q_pop;
  logic  out_kind;
  logic  nal_end;
  logic  eof_beat;
  logic [7:0]  out_byte;
  logic [63:0] out_timestamp;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = q_space;
  assign accept        = s_axis_tvalid && s_axis_tready;

  lpab_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .opcode        (s_axis_tuser),
    .data_byte     (s_axis_tdata[7:0]),
    .sample_length (s_axis_tdata[38:8]),
    .timestamp     (s_axis_tdata[102:39]),
    .push          (q_push),
    .push_data     (q_push_data)
  );

  lpab_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .space     (q_space),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  lpab_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_kind      (out_kind),
    .out_byte      (out_byte),
    .out_timestamp (out_timestamp),
    .nal_end       (nal_end),
    .last_of_run   (m_axis_tlast)
  );

  assign m_axis_tdata = {out_timestamp, out_byte};
  assign m_axis_tuser = {nal_end, out_kind};
  assign eof_beat     = m_axis_tvalid && out_kind;

  // Checks
  `include "length_prefix_to_annexb_unit_assert.svh"

  // An end marker is a zero, closing item without a NAL end flag
  `LPAB_ASSERT_IMPL(a_eof_shape, eof_beat, m_axis_tlast && out_byte == 8'd0 && !nal_end)
  // The end of a NAL always closes the run of its input item
  `LPAB_ASSERT_IMPL(a_nal_end_last, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)
  // Input stalls only when the queue holds commands
  `LPAB_ASSERT_IMPL(a_stall_has_work, !s_axis_tready, q_valid)
  // A start-code burst continues without a gap
  `LPAB_ASSERT_NEXT(a_sc_burst, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)

endmodule
